[rtl/core/plwe_pkg.sv]
package plwe_pkg;

    localparam int WINDOW_DEPTH = 40;
    localparam int COUNT_BITS   = 16;
    localparam int SUM_BITS     = 22;
    localparam int FRESH_BITS   = 14;
    localparam int WIN_MS_BITS  = 16;
    localparam int TENTHS_BITS  = 10;

    localparam logic [1:0] CMD_REPORT = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic CFG_FRESHNESS = 1'b0;
    localparam logic CFG_WINDOW    = 1'b1;

    localparam logic [1:0] ST_STALE    = 2'd0;
    localparam logic [1:0] ST_NO_PKTS  = 2'd1;
    localparam logic [1:0] ST_VALID    = 2'd2;

    localparam logic [FRESH_BITS-1:0]  FRESH_RESET  = 14'd3000;
    localparam logic [WIN_MS_BITS-1:0] WINDOW_RESET = 16'd3000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;      // latch the input request
        logic report;    // apply report bookkeeping
        logic clear;     // forget all link state
        logic age_step;  // test head entry for aging
        logic sum_start; // clear accumulators, start walk
        logic sum_step;  // add one entry
        logic div_start; // start the divider
        logic div_step;  // one quotient bit
        logic finish;    // register the result
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_report;
        logic is_tick;
        logic is_clear;
        logic age_done;
        logic sum_done;
        logic div_done;
    } sts_t;

endpackage

[rtl/core/packet_loss_window_estimator_top.sv]
// Packet loss window estimator. Requests enter on s_*: command 0 is a counter
// report (no result), 1 an evaluate tick and 2 a link-lost clear (one result on
// m_* each). One request is in work at a time. A tick first ages out old
// samples, then sums the window through the single ring read port walked one
// entry a cycle, then runs an 11-step serial divider. Requests are accepted
// whenever the block is idle; a result still waiting on m_* holds the next
// tick or clear at its finish step until it is taken.
module packet_loss_window_estimator_top #(
    parameter int WINDOW_DEPTH = plwe_pkg::WINDOW_DEPTH,
    parameter int COUNT_BITS   = plwe_pkg::COUNT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // command, now_ms, report_stamp, out_recent, out_total, lost_recent,
    // lost_total, fec_recent, fec_total (lowest first), zero padded
    input  logic [215:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // has_data, status, level, loss_tenths, out_sum, lost_sum, fec_sum
    output logic [87:0]   m_tdata
);

    plwe_pkg::ctl_t ctl;
    plwe_pkg::sts_t sts;
    logic [87:0]    res;

    assign cfg_ready = 1'b1;
    assign m_tdata   = res;

    plwe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    plwe_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   ({12'd0, s_tdata}),
        .ctl       (ctl),
        .sts       (sts),
        .res       (res)
    );

endmodule

[rtl/core/plwe_datapath.sv]
module plwe_datapath #(
    parameter int WINDOW_DEPTH = plwe_pkg::WINDOW_DEPTH,
    parameter int COUNT_BITS   = plwe_pkg::COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [227:0]        in_data,
    input  plwe_pkg::ctl_t      ctl,
    output plwe_pkg::sts_t      sts,
    output logic [87:0]         res
);

    localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SB = plwe_pkg::SUM_BITS;
    localparam int AW = COUNT_BITS + CW;
    localparam int DW = AW + 11;
    localparam logic [SB-1:0] SUM_MAX = {SB{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers
    logic [plwe_pkg::FRESH_BITS-1:0]  fresh_ms_reg;
    logic [plwe_pkg::WIN_MS_BITS-1:0] window_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_ms_reg  <= plwe_pkg::FRESH_RESET;
            window_ms_reg <= plwe_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == plwe_pkg::CFG_FRESHNESS)
                fresh_ms_reg <= cfg_data[plwe_pkg::FRESH_BITS-1:0];
            else
                window_ms_reg <= cfg_data;
        end
    end

    // Latched request
    logic [1:0]  cmd_reg;
    logic [31:0] now_reg, stamp_reg, o_tot_reg, l_tot_reg, f_tot_reg;
    logic [15:0] o_rec_reg, l_rec_reg, f_rec_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            cmd_reg   <= in_data[1:0];
            now_reg   <= in_data[33:2];
            stamp_reg <= in_data[65:34];
            o_rec_reg <= in_data[81:66];
            o_tot_reg <= in_data[113:82];
            l_rec_reg <= in_data[129:114];
            l_tot_reg <= in_data[161:130];
            f_rec_reg <= in_data[177:162];
            f_tot_reg <= in_data[209:178];
        end
    end

    assign sts.is_report = (cmd_reg == plwe_pkg::CMD_REPORT);
    assign sts.is_tick   = (cmd_reg == plwe_pkg::CMD_TICK);
    assign sts.is_clear  = (cmd_reg == plwe_pkg::CMD_CLEAR);

    // Link state
    logic [IW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   p_out_reg, p_lost_reg, p_fec_reg, p_stamp_reg, p_arr_reg;
    logic          have_prev_reg, have_arr_reg, video_reg;

    // Ring memory, one word per sample
    logic [32+3*COUNT_BITS-1:0] ring_mem [WINDOW_DEPTH];
    logic [32+3*COUNT_BITS-1:0] rd_reg;
    logic [IW-1:0]              rd_addr;
    logic [IW-1:0]              walk_reg;
    logic [CW-1:0]              left_reg;

    function automatic logic [COUNT_BITS-1:0] sat(input logic [31:0] v);
        if (v > 32'(CNT_MAX))
            return CNT_MAX;
        return COUNT_BITS'(v);
    endfunction

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] v);
        if (32'(v) == WINDOW_DEPTH - 1)
            return '0;
        return v + 1'b1;
    endfunction

    // Report decisions
    logic                  bad, restart, old, act;
    logic [COUNT_BITS-1:0] d_o, d_l, d_f;
    logic [31:0]           arr_age;
    logic [IW:0]           slot_sum;
    logic [IW-1:0]         slot;

    always_comb
    begin
        arr_age = now_reg - p_arr_reg;
        bad = ({16'd0, o_rec_reg} > o_tot_reg) || ({16'd0, l_rec_reg} > l_tot_reg)
            || ({16'd0, f_rec_reg} > f_tot_reg);
        restart = !have_prev_reg || (o_tot_reg < p_out_reg) || (l_tot_reg < p_lost_reg)
            || (f_tot_reg < p_fec_reg)
            || (have_arr_reg && (arr_age >= 32'(fresh_ms_reg)));
        old = !restart && (stamp_reg <= p_stamp_reg);
        if (restart)
        begin
            d_o = sat({16'd0, o_rec_reg});
            d_l = sat({16'd0, l_rec_reg});
            d_f = sat({16'd0, f_rec_reg});
        end
        else
        begin
            d_o = sat(o_tot_reg - p_out_reg);
            d_l = sat(l_tot_reg - p_lost_reg);
            d_f = sat(f_tot_reg - p_fec_reg);
        end
        act = (d_o != '0) || (d_l != '0);
        slot_sum = restart ? '0 : ((IW+1)'(head_reg) + (IW+1)'(count_reg));
        if (32'(slot_sum) >= WINDOW_DEPTH)
            slot = IW'(slot_sum - (IW+1)'(WINDOW_DEPTH));
        else
            slot = IW'(slot_sum);
    end

    logic do_write;
    assign do_write = ctl.report && !bad && !old && act;

    assign rd_addr = ctl.sum_start ? head_reg : (ctl.sum_step ? inc_idx(walk_reg) : head_reg);

    always_ff @(posedge clk)
    begin
        if (do_write)
            ring_mem[slot] <= {d_f, d_l, d_o, now_reg};
        rd_reg <= ring_mem[rd_addr];
    end

    // Aging check uses the registered head entry
    logic [31:0] age;
    assign age = now_reg - rd_reg[31:0];
    assign sts.age_done = (count_reg == '0) || (age < 32'(window_ms_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            p_out_reg     <= '0;
            p_lost_reg    <= '0;
            p_fec_reg     <= '0;
            p_stamp_reg   <= '0;
            p_arr_reg     <= '0;
            have_prev_reg <= 1'b0;
            have_arr_reg  <= 1'b0;
            video_reg     <= 1'b0;
        end
        else if (ctl.clear)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            p_out_reg     <= '0;
            p_lost_reg    <= '0;
            p_fec_reg     <= '0;
            p_stamp_reg   <= '0;
            p_arr_reg     <= '0;
            have_prev_reg <= 1'b0;
            have_arr_reg  <= 1'b0;
            video_reg     <= 1'b0;
        end
        else if (ctl.report && !bad && !old)
        begin
            p_out_reg     <= o_tot_reg;
            p_lost_reg    <= l_tot_reg;
            p_fec_reg     <= f_tot_reg;
            have_prev_reg <= 1'b1;
            p_stamp_reg   <= stamp_reg;
            p_arr_reg     <= now_reg;
            have_arr_reg  <= 1'b1;
            video_reg     <= act;
            if (!act)
            begin
                head_reg  <= '0;
                count_reg <= '0;
            end
            else if (restart)
            begin
                head_reg  <= '0;
                count_reg <= CW'(1);
            end
            else if (32'(count_reg) < WINDOW_DEPTH)
                count_reg <= count_reg + 1'b1;
            else
                head_reg <= inc_idx(head_reg);
        end
        else if (ctl.age_step && !sts.age_done)
        begin
            head_reg  <= inc_idx(head_reg);
            count_reg <= count_reg - 1'b1;
        end
    end

    // Window sums, one entry per cycle
    logic [AW-1:0] so_reg, sl_reg, sf_reg;
    logic          sum_live_reg;

    assign sts.sum_done = !sum_live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_live_reg <= 1'b0;
        else if (ctl.sum_start)
            sum_live_reg <= (count_reg != '0);
        else if (ctl.sum_step && left_reg == CW'(1))
            sum_live_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_start)
        begin
            so_reg   <= '0;
            sl_reg   <= '0;
            sf_reg   <= '0;
            walk_reg <= head_reg;
            left_reg <= count_reg;
        end
        else if (ctl.sum_step)
        begin
            so_reg   <= so_reg + AW'(rd_reg[32 +: COUNT_BITS]);
            sl_reg   <= sl_reg + AW'(rd_reg[32+COUNT_BITS +: COUNT_BITS]);
            sf_reg   <= sf_reg + AW'(rd_reg[32+2*COUNT_BITS +: COUNT_BITS]);
            walk_reg <= inc_idx(walk_reg);
            left_reg <= left_reg - 1'b1;
        end
    end

    // Restoring divider: ceil(1000*lost/tot)
    // The quotient fits 11 bits, so the upper dividend bits seed the remainder
    // and only the low 11 bits are shifted in.
    logic [AW:0]   tot;
    logic          fresh, valid;
    logic [DW-1:0] num_init;
    logic [DW-1:0] num_reg, rem_reg;
    logic [10:0]   q_reg;
    logic [3:0]    dcnt_reg;
    logic [DW:0]   trial;

    assign tot      = {1'b0, so_reg} + {1'b0, sl_reg};
    assign fresh    = have_arr_reg && ((now_reg - p_arr_reg) < 32'(fresh_ms_reg));
    assign valid    = fresh && video_reg && (tot != '0);
    assign num_init = DW'(sl_reg) * DW'(1000) + DW'(tot) - DW'(1);
    assign trial    = {rem_reg, num_reg[DW-1]};
    assign sts.div_done = (dcnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (ctl.div_start)
            dcnt_reg <= 4'd11;
        else if (ctl.div_step && dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            num_reg <= num_init << (DW - 11);
            rem_reg <= num_init >> 11;
            q_reg   <= '0;
        end
        else if (ctl.div_step)
        begin
            num_reg <= num_reg << 1;
            if (trial >= (DW+1)'(tot))
            begin
                rem_reg <= DW'(trial - (DW+1)'(tot));
                q_reg   <= {q_reg[9:0], 1'b1};
            end
            else
            begin
                rem_reg <= DW'(trial);
                q_reg   <= {q_reg[9:0], 1'b0};
            end
        end
    end

    // Result register
    logic [10:0]    tenths;
    logic [3:0]     lvl;
    logic [1:0]     st;

    always_comb
    begin
        tenths = valid ? q_reg : '0;
        if (!valid)
            lvl = 4'hF;
        else if (tenths >= 11'd500)
            lvl = 4'd0;
        else if (tenths >= 11'd200)
            lvl = 4'd1;
        else if (tenths >= 11'd50)
            lvl = 4'd2;
        else if (tenths != '0)
            lvl = 4'd3;
        else
            lvl = 4'd4;
        st = !fresh ? plwe_pkg::ST_STALE : (!valid ? plwe_pkg::ST_NO_PKTS : plwe_pkg::ST_VALID);
    end

    function automatic logic [SB-1:0] sat_sum(input logic [AW-1:0] v);
        if (AW > SB && v > AW'(SUM_MAX))
            return SUM_MAX;
        return SB'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
            res <= {5'd0, sat_sum(sf_reg), sat_sum(sl_reg), sat_sum(so_reg),
                    tenths[9:0], lvl, st, valid};
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= WINDOW_DEPTH) else $error("window count overflow");
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < WINDOW_DEPTH) else $error("head out of range");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (count_reg == '0 && !have_prev_reg)) else $error("clear failed");
`endif

endmodule

[rtl/core/plwe_ctrl.sv]
module plwe_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  plwe_pkg::sts_t  sts,
    output plwe_pkg::ctl_t  ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_AGE  = 3'd2;
    localparam logic [2:0] S_AGW  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // Input taken whenever idle; a pending result only holds the finish step
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        ov_next    = ov_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    ctl.take   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.is_report)
                begin
                    ctl.report = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.is_tick || sts.is_clear)
                begin
                    ctl.clear  = sts.is_clear;
                    state_next = S_AGW;
                end
                else
                    state_next = S_IDLE;
            end
            S_AGW:
                state_next = S_AGE; // head entry read settles
            S_AGE:
            begin
                ctl.age_step = 1'b1;
                if (sts.age_done)
                begin
                    ctl.sum_start = 1'b1;
                    state_next    = S_SUM;
                end
                else
                    state_next = S_AGW;
            end
            S_SUM:
            begin
                if (sts.sum_done)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    ctl.sum_step = 1'b1;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                begin
                    ctl.div_step = 1'b0;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait here while the previous result is still held
                if (!ov_reg || m_tready)
                begin
                    ctl.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> (!ov_reg || m_tready)) else $error("result overwritten while pending");
    a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> m_tvalid) else $error("result not presented");
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctl.report, ctl.sum_step, ctl.div_step, ctl.finish}) <= 1)
        else $error("overlapping phases");
`endif

endmodule

[verif/testbench.sv]
module testbench;

    localparam int CYCLE_LIMIT = 2000000;

    // one request as it sits in s_tdata
    typedef struct packed {
        logic [31:0] fec_total;
        logic [15:0] fec_recent;
        logic [31:0] lost_total;
        logic [15:0] lost_recent;
        logic [31:0] out_total;
        logic [15:0] out_recent;
        logic [31:0] report_stamp;
        logic [31:0] now_ms;
        logic [1:0]  command;
    } link_req_t;

    // one loss estimate as it sits in m_tdata
    typedef struct packed {
        logic [21:0] fec_sum;
        logic [21:0] lost_sum;
        logic [21:0] out_sum;
        logic [9:0]  loss_tenths;
        logic [3:0]  level;
        logic [1:0]  status;
        logic        has_data;
    } loss_est_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_index;
    logic [15:0]   cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [215:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [87:0]   m_tdata;

    packet_loss_window_estimator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state
    logic [31:0] fresh_lim;
    logic [31:0] win_lim;
    logic [31:0] smp_time [plwe_pkg::WINDOW_DEPTH];
    logic [15:0] smp_out  [plwe_pkg::WINDOW_DEPTH];
    logic [15:0] smp_lost [plwe_pkg::WINDOW_DEPTH];
    logic [15:0] smp_fec  [plwe_pkg::WINDOW_DEPTH];
    int unsigned head_idx;
    int unsigned fill;
    logic [31:0] last_out_tot;
    logic [31:0] last_lost_tot;
    logic [31:0] last_fec_tot;
    logic        seen_report;
    logic [31:0] last_stamp;
    logic [31:0] last_arrival;
    logic        seen_arrival;
    logic        link_active;

    loss_est_t   pending_est [$];
    int          mismatch_cnt = 0;
    int          est_checked = 0;
    int          req_sent;
    longint      cycle_cnt = 0;
    int          hold_off;
    bit          hold_req = 1'b0;
    bit          hold_seen;
    int          rx_wait;
    bit          rx_random;

    // local link time and report counters used by the stimulus
    logic [31:0] t_now;
    logic [31:0] t_stamp;
    logic [31:0] c_out;
    logic [31:0] c_lost;
    logic [31:0] c_fec;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    always @(posedge clk)
    begin
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic forget_link();
        head_idx = 0;
        fill = 0;
        last_out_tot = '0;
        last_lost_tot = '0;
        last_fec_tot = '0;
        seen_report = 1'b0;
        last_stamp = '0;
        last_arrival = '0;
        seen_arrival = 1'b0;
        link_active = 1'b0;
    endtask

    task automatic apply_report(input link_req_t r);
        logic restart;
        logic [15:0] o, l, f;
        int unsigned slot;
        if (r.out_recent > r.out_total || r.lost_recent > r.lost_total ||
            r.fec_recent > r.fec_total)
            return;
        restart = !seen_report || r.out_total < last_out_tot ||
                  r.lost_total < last_lost_tot || r.fec_total < last_fec_tot ||
                  (seen_arrival && (r.now_ms - last_arrival) >= fresh_lim);
        if (!restart && r.report_stamp <= last_stamp)
            return;
        if (restart)
        begin
            head_idx = 0;
            fill = 0;
            o = r.out_recent;
            l = r.lost_recent;
            f = r.fec_recent;
        end
        else
        begin
            o = sat16(r.out_total - last_out_tot);
            l = sat16(r.lost_total - last_lost_tot);
            f = sat16(r.fec_total - last_fec_tot);
        end
        last_out_tot = r.out_total;
        last_lost_tot = r.lost_total;
        last_fec_tot = r.fec_total;
        seen_report = 1'b1;
        last_stamp = r.report_stamp;
        last_arrival = r.now_ms;
        seen_arrival = 1'b1;
        link_active = (o != 0) || (l != 0);
        if (!link_active)
        begin
            head_idx = 0;
            fill = 0;
            return;
        end
        slot = (head_idx + fill) % plwe_pkg::WINDOW_DEPTH;
        smp_time[slot] = r.now_ms;
        smp_out[slot] = o;
        smp_lost[slot] = l;
        smp_fec[slot] = f;
        if (fill < plwe_pkg::WINDOW_DEPTH)
            fill++;
        else
            head_idx = (head_idx + 1) % plwe_pkg::WINDOW_DEPTH;
    endtask

    function automatic loss_est_t estimate_loss(input logic [31:0] now);
        longint unsigned so, sl, sf, tot, tenths;
        logic fresh, valid;
        int lvl;
        loss_est_t e;
        so = 0; sl = 0; sf = 0; tenths = 0; lvl = -1;
        while (fill > 0 && (now - smp_time[head_idx]) >= win_lim)
        begin
            head_idx = (head_idx + 1) % plwe_pkg::WINDOW_DEPTH;
            fill--;
        end
        for (int i = 0; i < fill; i++)
        begin
            so += smp_out[(head_idx + i) % plwe_pkg::WINDOW_DEPTH];
            sl += smp_lost[(head_idx + i) % plwe_pkg::WINDOW_DEPTH];
            sf += smp_fec[(head_idx + i) % plwe_pkg::WINDOW_DEPTH];
        end
        fresh = seen_arrival && ((now - last_arrival) < fresh_lim);
        tot = so + sl;
        valid = fresh && link_active && tot > 0;
        if (valid)
        begin
            tenths = (1000 * sl + tot - 1) / tot;
            if (tenths >= 500) lvl = 0;
            else if (tenths >= 200) lvl = 1;
            else if (tenths >= 50) lvl = 2;
            else if (tenths > 0) lvl = 3;
            else lvl = 4;
        end
        e.has_data = valid;
        e.status = !fresh ? plwe_pkg::ST_STALE :
                   (!valid ? plwe_pkg::ST_NO_PKTS : plwe_pkg::ST_VALID);
        e.level = lvl[3:0];
        e.loss_tenths = tenths[9:0];
        e.out_sum = (so > 64'h3FFFFF) ? 22'h3FFFFF : so[21:0];
        e.lost_sum = (sl > 64'h3FFFFF) ? 22'h3FFFFF : sl[21:0];
        e.fec_sum = (sf > 64'h3FFFFF) ? 22'h3FFFFF : sf[21:0];
        return e;
    endfunction

    task automatic predict_request(input link_req_t r);
        case (r.command)
            plwe_pkg::CMD_REPORT: apply_report(r);
            plwe_pkg::CMD_TICK:   pending_est.push_back(estimate_loss(r.now_ms));
            plwe_pkg::CMD_CLEAR:
            begin
                forget_link();
                pending_est.push_back(estimate_loss(r.now_ms));
            end
            default: ;
        endcase
    endtask

    // send one request, predicting at acceptance; valid stays up into the next
    // request when there is no gap
    task automatic send_request(input link_req_t r, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= 216'(r);
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_request(r);
        req_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == plwe_pkg::CFG_FRESHNESS)
            fresh_lim = {18'd0, val[13:0]};
        else
            win_lim = {16'd0, val};
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_est.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // result side: drawn wait per result, or a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        int draw;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_off <= 0;
            hold_seen <= hold_req;
            rx_wait <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_off <= 600;
            m_tready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end
        else if (m_tvalid && m_tready && rx_random)
        begin
            draw = $urandom_range(0, 16);
            rx_wait <= draw;
            m_tready <= (draw == 0);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        loss_est_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = loss_est_t'(m_tdata[82:0]);
            if (pending_est.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected estimate %h", m_tdata);
            end
            else
            begin
                want = pending_est.pop_front();
                est_checked++;
                if (got !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("estimate %0d: expected has=%0d st=%0d lvl=%0d t=%0d o=%0d l=%0d f=%0d got has=%0d st=%0d lvl=%0d t=%0d o=%0d l=%0d f=%0d",
                            est_checked, want.has_data, want.status, $signed(want.level),
                            want.loss_tenths, want.out_sum, want.lost_sum, want.fec_sum,
                            got.has_data, got.status, $signed(got.level), got.loss_tenths,
                            got.out_sum, got.lost_sum, got.fec_sum);
                end
            end
        end
    end

    function automatic link_req_t mk_req(input logic [1:0] cmd);
        link_req_t r;
        r = '0;
        r.command = cmd;
        r.now_ms = t_now;
        return r;
    endfunction

    // a well-formed report advancing the counters
    function automatic link_req_t next_report(input int max_step);
        link_req_t r;
        logic [31:0] dout, dlost, dfec;
        dout = $urandom_range(0, max_step);
        dlost = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_step / 4 + 1);
        dfec = $urandom_range(0, dlost + 1);
        c_out += dout; c_lost += dlost; c_fec += dfec;
        t_stamp += $urandom_range(1, 300);
        r = mk_req(plwe_pkg::CMD_REPORT);
        r.report_stamp = t_stamp;
        r.out_total = c_out;
        r.lost_total = c_lost;
        r.fec_total = c_fec;
        r.out_recent = (dout > 32'hFFFF) ? 16'hFFFF : dout[15:0];
        r.lost_recent = (dlost > 32'hFFFF) ? 16'hFFFF : dlost[15:0];
        r.fec_recent = (dfec > 32'hFFFF) ? 16'hFFFF : dfec[15:0];
        if (r.out_recent > c_out) r.out_recent = c_out[15:0];
        if (r.lost_recent > c_lost) r.lost_recent = c_lost[15:0];
        if (r.fec_recent > c_fec) r.fec_recent = c_fec[15:0];
        return r;
    endfunction

    task automatic test_directed();
        link_req_t r;
        // tick with no data, then a first report restarting the window
        t_now = 32'd1000;
        send_request(mk_req(plwe_pkg::CMD_TICK));
        c_out = 100; c_lost = 0; c_fec = 0; t_stamp = 50;
        r = next_report(200);
        send_request(r);
        t_now += 100;
        send_request(next_report(200));
        send_request(mk_req(plwe_pkg::CMD_TICK));
        // recent above total is ignored
        r = next_report(100);
        r.lost_recent = 16'hFFFF;
        r.lost_total = 32'd5;
        send_request(r);
        // old stamp is ignored
        r = next_report(100);
        r.report_stamp = 32'd0;
        send_request(r);
        // huge deltas saturate
        t_now += 100;
        c_out += 32'h0010_0000; c_lost += 32'h0002_0000; t_stamp += 10;
        r = mk_req(plwe_pkg::CMD_REPORT);
        r.report_stamp = t_stamp; r.out_total = c_out; r.lost_total = c_lost;
        r.fec_total = c_fec; r.out_recent = 16'hFFFF; r.lost_recent = 16'hFFFF;
        send_request(r);
        send_request(mk_req(plwe_pkg::CMD_TICK));
        // no traffic report
        t_now += 100; t_stamp += 10;
        r = mk_req(plwe_pkg::CMD_REPORT);
        r.report_stamp = t_stamp; r.out_total = c_out; r.lost_total = c_lost;
        r.fec_total = c_fec;
        send_request(r);
        send_request(mk_req(plwe_pkg::CMD_TICK));
        // all-lost traffic: worst level
        t_now += 100;
        c_lost += 500;
        r = next_report(0);
        send_request(r);
        send_request(mk_req(plwe_pkg::CMD_TICK));
        // counter restart going backwards
        t_now += 100;
        c_out = 3; c_lost = 1; c_fec = 0; t_stamp = 32'hFFFF_FFF0;
        r = mk_req(plwe_pkg::CMD_REPORT);
        r.report_stamp = t_stamp; r.out_total = 32'hFFFF_FFFF; r.lost_total = 32'hFFFF_FFFF;
        r.fec_total = 32'hFFFF_FFFF; r.out_recent = 16'hFFFF; r.lost_recent = 16'h1;
        r.fec_recent = 16'hFFFF; r.now_ms = 32'hFFFF_FFFF;
        send_request(r);
        r = mk_req(plwe_pkg::CMD_TICK); r.now_ms = 32'hFFFF_FFFF; r.report_stamp = '1;
        send_request(r);
        send_request(mk_req(plwe_pkg::CMD_REPORT));
        // stale data, unknown command, link lost clear
        t_now += 20000;
        send_request(mk_req(plwe_pkg::CMD_TICK));
        r = mk_req(2'd3); r.out_total = '1; r.lost_total = '1;
        send_request(r);
        send_request(mk_req(plwe_pkg::CMD_CLEAR));
        drain();
    endtask

    // window full and random traffic under one register setting
    task automatic test_random(input int n, input int max_step);
        link_req_t r;
        int k;
        c_out = 0; c_lost = 0; c_fec = 0; t_stamp = $urandom;
        for (int i = 0; i < n; i++)
        begin
            t_now += $urandom_range(20, 250);
            k = $urandom_range(0, 19);
            if (k < 13)
                r = next_report(max_step);
            else if (k < 17)
                r = mk_req(plwe_pkg::CMD_TICK);
            else if (k == 17)
            begin
                r = link_req_t'(210'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom}));
                r.command = plwe_pkg::CMD_REPORT;
                r.now_ms = t_now;
            end
            else if (k == 18)
            begin
                t_now += $urandom_range(0, 20000);
                r = mk_req(plwe_pkg::CMD_TICK);
            end
            else
                r = mk_req(($urandom_range(0, 3) == 0) ? 2'd3 : plwe_pkg::CMD_CLEAR);
            send_request(r);
        end
        drain();
    endtask

    // receiver holds off while sender keeps pushing reports and ticks
    task automatic test_backpressure();
        link_req_t r;
        hold_req = ~hold_req;
        for (int i = 0; i < 30; i++)
        begin
            t_now += 100;
            r = (i % 2) ? mk_req(plwe_pkg::CMD_TICK) : next_report(1000);
            send_request(r, 1);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0;
        req_sent = 0;
        rx_random = 1'b1;
        fresh_lim = 32'(plwe_pkg::FRESH_RESET); win_lim = 32'(plwe_pkg::WINDOW_RESET);
        forget_link();
        t_now = 0; t_stamp = 0; c_out = 0; c_lost = 0; c_fec = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250, 2000);
        write_reg(plwe_pkg::CFG_FRESHNESS, 16'd15000);
        write_reg(plwe_pkg::CFG_WINDOW, 16'd60000);
        test_random(200, 70000);
        test_backpressure();
        write_reg(plwe_pkg::CFG_FRESHNESS, 16'd0);
        write_reg(plwe_pkg::CFG_WINDOW, 16'd0);
        test_random(60, 500);
        write_reg(plwe_pkg::CFG_FRESHNESS, 16'd5000);
        write_reg(plwe_pkg::CFG_WINDOW, 16'd1);
        test_random(80, 500);
        rx_random = 1'b0;
        write_reg(plwe_pkg::CFG_FRESHNESS, 16'd3000);
        write_reg(plwe_pkg::CFG_WINDOW, 16'd8000);
        test_random(150, 3000);
        rx_random = 1'b1;
        write_reg(plwe_pkg::CFG_WINDOW, 16'd2000);
        test_random(150, 300);

        $display("sent %0d requests, checked %0d loss estimates", req_sent, est_checked);
        $display("covered report rules, aging, saturation, clears and register extremes");
        if (mismatch_cnt == 0 && pending_est.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
